// ----- hw/rtl/sdff_pkg.sv -----
// ============================================================================
// sdff_pkg
// Types and constants shared by the signed decimal field formatter.
// ============================================================================
package sdff_pkg;

    localparam int VALUE_W = 28;
    localparam int MAG_W   = 27;
    localparam int NDIGITS = 7;
    localparam int BCD_W   = 4 * NDIGITS;

    localparam logic [2:0] FMT_U7 = 3'd0;
    localparam logic [2:0] FMT_S7 = 3'd1;
    localparam logic [2:0] FMT_U5 = 3'd2;
    localparam logic [2:0] FMT_S5 = 3'd3;
    localparam logic [2:0] FMT_S3 = 3'd4;

    localparam logic [VALUE_W-1:0] LIMIT7 = 28'd10000000;
    localparam logic [VALUE_W-1:0] LIMIT5 = 28'd100000;
    localparam logic [VALUE_W-1:0] LIMIT3 = 28'd1000;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [2:0]                format;
        logic                      blank_leading;
        logic [6:0]                position;
    } in_t;

    typedef struct packed {
        logic [7:0] code;
        logic       is_command;
        logic       last;
        logic       overflow;
    } out_t;

    typedef struct packed {
        logic [2:0]         fmt;
        logic               blank;
        logic [6:0]         pos;
        logic               neg;
        logic [VALUE_W-1:0] full;
    } front_t;

    typedef struct packed {
        logic [2:0]       fmt;
        logic             blank;
        logic [6:0]       pos;
        logic             neg;
        logic             ovf;
        logic [BCD_W-1:0] bcd;
        logic [MAG_W-1:0] bin;
    } pipe_t;

    // one shift-and-add-3 step; digits above the kept ones are dropped
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                      input logic          bin_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < NDIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5)
                adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

endpackage

// ----- hw/rtl/sdff_front.sv -----
// ============================================================================
// sdff_front
// Input register: sign split and two's complement magnitude.
// ============================================================================
module sdff_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           load,
    input  sdff_pkg::in_t  d,
    output logic           valid,
    output sdff_pkg::front_t q
);
    import sdff_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    front_t data_reg;
    front_t data_next;

    always_comb
    begin
        valid_next     = adv ? load : valid_reg;
        data_next.fmt   = d.format;
        data_next.blank = d.blank_leading;
        data_next.pos   = d.position;
        data_next.neg   = d.value[VALUE_W-1];
        data_next.full  = d.value[VALUE_W-1] ? (~d.value + 28'd1) : d.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && load)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign q     = data_reg;

endmodule

// ----- hw/rtl/sdff_dabble.sv -----
// ============================================================================
// sdff_dabble
// One pipeline stage of the binary to BCD conversion, STEPS bits per stage.
// ============================================================================
module sdff_dabble #(
    parameter int STEPS = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            valid_in,
    input  sdff_pkg::pipe_t d,
    output logic            valid_out,
    output sdff_pkg::pipe_t q
);
    import sdff_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    pipe_t data_reg;
    pipe_t data_next;

    always_comb
    begin
        data_next = d;
        for (int i = 0; i < STEPS; i++) begin
            data_next.bcd = dabble_step(data_next.bcd, data_next.bin[MAG_W-1]);
            data_next.bin = {data_next.bin[MAG_W-2:0], 1'b0};
        end
        valid_next = adv ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_in)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign q         = data_reg;

endmodule

// ----- hw/rtl/sdff_emit.sv -----
// ============================================================================
// sdff_emit
// Byte sequencer: command beat, optional sign, digits with zero blanking.
// ============================================================================
module sdff_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    input  sdff_pkg::pipe_t d,
    output logic            ready,
    output logic            strobe,
    output sdff_pkg::out_t  result
);
    import sdff_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMD   = 4'b0010,
        ST_SIGN  = 4'b0100,
        ST_DIGIT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [6:0]       pos_reg, pos_next;
    logic             neg_reg, neg_next;
    logic             ovf_reg, ovf_next;
    logic             sign_reg, sign_next;
    logic             lead_reg, lead_next;
    logic [2:0]       idx_reg, idx_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic             strobe_reg, strobe_next;
    out_t             result_reg, result_next;
    logic [3:0]       digit;
    logic             blank_now;
    logic             fmt_bad;
    logic             load;

    assign digit     = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign blank_now = lead_reg && (idx_reg != 3'd0) && (digit == 4'd0);
    assign fmt_bad   = d.fmt > FMT_S3;
    assign ready     = (state_reg == ST_IDLE) ||
                       ((state_reg == ST_DIGIT) && (idx_reg == 3'd0)) || fmt_bad;
    assign load      = valid && ready && !fmt_bad;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        neg_next    = neg_reg;
        ovf_next    = ovf_reg;
        sign_next   = sign_reg;
        lead_next   = lead_reg;
        idx_next    = idx_reg;
        bcd_next    = bcd_reg;
        strobe_next = 1'b0;
        result_next = '0;
        result_next.overflow = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_CMD:
            begin
                strobe_next            = 1'b1;
                result_next.code       = {1'b1, pos_reg};
                result_next.is_command = 1'b1;
                state_next             = sign_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                strobe_next      = 1'b1;
                result_next.code = neg_reg ? CHAR_MINUS : CHAR_SPACE;
                state_next       = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                strobe_next      = 1'b1;
                result_next.code = blank_now ? CHAR_SPACE : {CHAR_DIGIT_HI, digit};
                result_next.last = (idx_reg == 3'd0);
                lead_next        = blank_now;
                idx_next         = idx_reg - 3'd1;
                if (idx_reg == 3'd0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            state_next = ST_CMD;
            pos_next   = d.pos;
            neg_next   = d.neg;
            ovf_next   = d.ovf;
            lead_next  = d.blank;
            bcd_next   = d.bcd;
            case (d.fmt) inside
                FMT_U7:         begin idx_next = 3'd6; sign_next = 1'b0; end
                FMT_S7:         begin idx_next = 3'd6; sign_next = 1'b1; end
                FMT_U5:         begin idx_next = 3'd4; sign_next = 1'b0; end
                FMT_S5:         begin idx_next = 3'd4; sign_next = 1'b1; end
                default:        begin idx_next = 3'd2; sign_next = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        sign_reg   <= sign_next;
        lead_reg   <= lead_next;
        idx_reg    <= idx_next;
        bcd_reg    <= bcd_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ----- hw/rtl/signed_decimal_field_formatter.sv -----
// ============================================================================
// signed_decimal_field_formatter
// Signed number to display field: position command plus ASCII characters.
// ============================================================================
// Usage:
//   An item (value, format, blank_leading, position) is taken at a rising
//   edge with start high and busy low. Each item produces a command beat
//   (0x80 + position, is_command set) followed by the field characters; the
//   final character carries last. Every beat is on result for one cycle with
//   strobe high; the receiver cannot hold beats off. Format codes 5 to 7
//   produce no beats.
//   Path: when the byte sequencer is free, the command beat passes the
//   input register, four BCD conversion stages, the sequencer load and the
//   output register.
//   Throughput: the byte sequencer sends one beat per cycle; an item is a
//   command beat, a sign beat on signed formats and 3/5/7 digit beats;
//   the pipeline holds up to five items besides the one being sent. busy is
//   high while the last conversion stage holds an item that the sequencer
//   cannot load yet.
//   Reset clears all valid bits and returns the sequencer to idle.
// ============================================================================
module signed_decimal_field_formatter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sdff_pkg::in_t  item,
    output logic           strobe,
    output sdff_pkg::out_t result
);
    import sdff_pkg::*;

    logic   adv;
    logic   front_valid;
    front_t front_q;
    pipe_t  conv_in;
    logic   v1, v2, v3, v4;
    pipe_t  q1, q2, q3, q4;
    logic   emit_ready;

    assign adv  = !v4 || emit_ready;
    assign busy = !adv;

    sdff_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .load  (start),
        .d     (item),
        .valid (front_valid),
        .q     (front_q)
    );

    always_comb
    begin
        conv_in.fmt   = front_q.fmt;
        conv_in.blank = front_q.blank;
        conv_in.pos   = front_q.pos;
        conv_in.neg   = front_q.neg;
        conv_in.bcd   = '0;
        conv_in.bin   = front_q.full[MAG_W-1:0];
        case (front_q.fmt) inside
            FMT_U7, FMT_S7: conv_in.ovf = front_q.full >= LIMIT7;
            FMT_U5, FMT_S5: conv_in.ovf = front_q.full >= LIMIT5;
            default:        conv_in.ovf = front_q.full >= LIMIT3;
        endcase
    end

    sdff_dabble #(.STEPS(7)) u_conv1 (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .valid_in(front_valid), .d(conv_in), .valid_out(v1), .q(q1)
    );

    sdff_dabble #(.STEPS(7)) u_conv2 (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .valid_in(v1), .d(q1), .valid_out(v2), .q(q2)
    );

    sdff_dabble #(.STEPS(7)) u_conv3 (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .valid_in(v2), .d(q2), .valid_out(v3), .q(q3)
    );

    sdff_dabble #(.STEPS(6)) u_conv4 (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .valid_in(v3), .d(q3), .valid_out(v4), .q(q4)
    );

    sdff_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (v4),
        .d      (q4),
        .ready  (emit_ready),
        .strobe (strobe),
        .result (result)
    );

    a_busy_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> v4)
        else $error("busy without an item in the last stage");

    a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.is_command |-> !result.last && result.code[7])
        else $error("malformed command beat");

    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |=> !strobe || result.is_command)
        else $error("character beat after last");

    a_cmd_then_char: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.is_command |=> strobe && !result.is_command)
        else $error("command beat not followed by a character");

    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.is_command |-> $past(strobe) && $stable(result.overflow))
        else $error("overflow changed within a field");

endmodule
